// ===== hw/rtl/bmlfa_pkg.sv =====
// Package with the types, sizes and state codes of the lowest free identifier allocator.
package bmlfa_pkg;

    localparam int ID_COUNT   = 1024;
    localparam int ID_W       = 10;
    localparam int ID_SPAN    = 1 << ID_W;
    localparam int ID_LIMIT   = (ID_COUNT < ID_SPAN) ? ID_COUNT : ID_SPAN;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int WORD_COUNT = (ID_LIMIT + WORD_W - 1) / WORD_W;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int LAST_WORD  = WORD_COUNT - 1;
    localparam int LAST_BITS  = ID_LIMIT - LAST_WORD * WORD_W;

    localparam logic [WORD_W-1:0] HIGH_MASK =
        ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

    localparam logic [ID_W-1:0] FIRST_INDEX_RESET = ID_W'(3);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic            opcode;
        logic [ID_W-1:0] free_index;
    } t_req;

    typedef struct packed {
        logic            status;
        logic [ID_W-1:0] given_index;
    } t_rsp;

    typedef struct packed {
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
    } t_mem_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE_WB,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/bmlfa_store.sv =====
// Bitmap word store with a registered read and per-word valid bits cleared at reset.
module bmlfa_store (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bmlfa_pkg::t_mem_req                   i_req,
    output logic [bmlfa_pkg::WORD_W-1:0]          o_rd_data
);

    logic [bmlfa_pkg::WORD_W-1:0]     r_mem [bmlfa_pkg::WORD_COUNT];
    logic [bmlfa_pkg::WORD_COUNT-1:0] r_valid;
    logic [bmlfa_pkg::WORD_W-1:0]     r_rd_data;
    logic                             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== hw/rtl/bmlfa_ctrl.sv =====
// Request sequencer: word scan for allocation, read-modify-write for release, result register.
module bmlfa_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bmlfa_pkg::ID_W-1:0]        i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bmlfa_pkg::t_req                   i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bmlfa_pkg::t_rsp                   o_out_data,
    output bmlfa_pkg::t_mem_req               o_mem_req,
    input  logic [bmlfa_pkg::WORD_W-1:0]      i_rd_data
);

    bmlfa_pkg::t_state                r_state, n_state;
    logic [bmlfa_pkg::ID_W-1:0]       r_first_index, n_first_index;
    logic [bmlfa_pkg::ID_W-1:0]       r_idx, n_idx;
    logic [bmlfa_pkg::WORD_AW-1:0]    r_chk_addr, n_chk_addr;
    bmlfa_pkg::t_rsp                  r_res, n_res;
    logic                             r_out_valid, n_out_valid;
    bmlfa_pkg::t_rsp                  r_out_data, n_out_data;

    logic                             in_fire;
    logic                             free_in_range;
    logic                             first_in_range;
    logic                             chk_is_last;
    logic                             out_slot_free;
    logic                             found;
    logic [bmlfa_pkg::WORD_AW-1:0]    first_word;
    logic [bmlfa_pkg::WORD_AW-1:0]    in_word;
    logic [bmlfa_pkg::WORD_AW-1:0]    idx_word;
    logic [bmlfa_pkg::WORD_W-1:0]     low_mask;
    logic [bmlfa_pkg::WORD_W-1:0]     masked;
    logic [bmlfa_pkg::WORD_W-1:0]     free_bits;
    logic [bmlfa_pkg::WORD_W-1:0]     lowest;
    logic [bmlfa_pkg::BIT_W-1:0]      pos;

    assign o_in_ready     = (r_state == bmlfa_pkg::S_IDLE);
    assign in_fire        = i_in_valid && o_in_ready;
    assign free_in_range  = (32'(i_in_data.free_index) < bmlfa_pkg::ID_COUNT);
    assign first_in_range = (32'(r_first_index) < bmlfa_pkg::ID_LIMIT);
    assign first_word     = r_first_index[bmlfa_pkg::BIT_W +: bmlfa_pkg::WORD_AW];
    assign in_word        = i_in_data.free_index[bmlfa_pkg::BIT_W +: bmlfa_pkg::WORD_AW];
    assign idx_word       = r_idx[bmlfa_pkg::BIT_W +: bmlfa_pkg::WORD_AW];
    assign chk_is_last    = (r_chk_addr == bmlfa_pkg::WORD_AW'(bmlfa_pkg::LAST_WORD));
    assign out_slot_free  = !r_out_valid || i_out_ready;

    assign low_mask  = (bmlfa_pkg::WORD_W'(1) << r_first_index[bmlfa_pkg::BIT_W-1:0])
                       - bmlfa_pkg::WORD_W'(1);
    assign masked    = i_rd_data
                     | ((r_chk_addr == first_word) ? low_mask : '0)
                     | (chk_is_last ? bmlfa_pkg::HIGH_MASK : '0);
    assign free_bits = ~masked;
    assign lowest    = free_bits & (~free_bits + bmlfa_pkg::WORD_W'(1));
    assign found     = |free_bits;

    always_comb begin
        pos = '0;
        for (int i = 0; i < bmlfa_pkg::WORD_W; i++) begin
            if (lowest[i]) begin
                pos = pos | bmlfa_pkg::BIT_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bmlfa_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.opcode == bmlfa_pkg::OP_FREE) begin
                        n_state = free_in_range ? bmlfa_pkg::S_FREE_WB : bmlfa_pkg::S_DONE;
                    end else begin
                        n_state = first_in_range ? bmlfa_pkg::S_SCAN : bmlfa_pkg::S_DONE;
                    end
                end
            end
            bmlfa_pkg::S_FREE_WB: begin
                n_state = bmlfa_pkg::S_DONE;
            end
            bmlfa_pkg::S_SCAN: begin
                if (found || chk_is_last) begin
                    n_state = bmlfa_pkg::S_DONE;
                end
            end
            bmlfa_pkg::S_DONE: begin
                if (out_slot_free) begin
                    n_state = bmlfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmlfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_mem_req = '0;
        case (r_state)
            bmlfa_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.opcode == bmlfa_pkg::OP_FREE) begin
                        o_mem_req.rd_en   = free_in_range;
                        o_mem_req.rd_addr = in_word;
                    end else begin
                        o_mem_req.rd_en   = first_in_range;
                        o_mem_req.rd_addr = first_word;
                    end
                end
            end
            bmlfa_pkg::S_FREE_WB: begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = idx_word;
                o_mem_req.wr_data = i_rd_data
                                  & ~(bmlfa_pkg::WORD_W'(1) << r_idx[bmlfa_pkg::BIT_W-1:0]);
            end
            bmlfa_pkg::S_SCAN: begin
                if (found) begin
                    o_mem_req.wr_en   = 1'b1;
                    o_mem_req.wr_addr = r_chk_addr;
                    o_mem_req.wr_data = i_rd_data | lowest;
                end else if (!chk_is_last) begin
                    o_mem_req.rd_en   = 1'b1;
                    o_mem_req.rd_addr = bmlfa_pkg::WORD_AW'(r_chk_addr + 1'b1);
                end
            end
            default: begin
                o_mem_req = '0;
            end
        endcase
    end

    always_comb begin
        n_first_index = i_cfg_we ? i_cfg_wdata : r_first_index;
        n_idx         = r_idx;
        n_chk_addr    = r_chk_addr;
        n_res         = r_res;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_data    = r_out_data;
        case (r_state)
            bmlfa_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_idx      = i_in_data.free_index;
                    n_chk_addr = first_word;
                    n_res      = '{status: bmlfa_pkg::ST_FAIL, given_index: '0};
                end
            end
            bmlfa_pkg::S_FREE_WB: begin
                n_res = '{status: bmlfa_pkg::ST_OK, given_index: '0};
            end
            bmlfa_pkg::S_SCAN: begin
                if (found) begin
                    n_res = '{status: bmlfa_pkg::ST_OK,
                              given_index: bmlfa_pkg::ID_W'({r_chk_addr, pos})};
                end else if (!chk_is_last) begin
                    n_chk_addr = bmlfa_pkg::WORD_AW'(r_chk_addr + 1'b1);
                end
            end
            bmlfa_pkg::S_DONE: begin
                if (out_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bmlfa_pkg::S_IDLE;
            r_first_index <= bmlfa_pkg::FIRST_INDEX_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_first_index <= n_first_index;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_chk_addr <= n_chk_addr;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_scan_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bmlfa_pkg::S_SCAN
        |-> r_chk_addr <= bmlfa_pkg::WORD_AW'(bmlfa_pkg::LAST_WORD))
        else $error("Scan address beyond the last bitmap word.");

    a_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en
        |-> (r_state == bmlfa_pkg::S_FREE_WB || r_state == bmlfa_pkg::S_SCAN))
        else $error("Bitmap written outside a release or scan.");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state != bmlfa_pkg::S_IDLE)
        else $error("Accepted transfer did not start work.");

    a_no_read_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.rd_en && o_mem_req.wr_en))
        else $error("Bitmap read and written in the same cycle.");

endmodule

// ===== hw/rtl/bitmap_lowest_free_id_allocator_top.sv =====
// Top level of the lowest free identifier allocator.
// The block hands out identifiers from a used/free bitmap held in a word store.
// Requests arrive on a valid/ready input channel: an allocate asks for the lowest
// free identifier at or above first_index, a free releases free_index.
// Each request gives exactly one result transfer on the valid/ready output channel,
// carrying a status and, for a successful allocate, the identifier handed out.
// One request is worked on at a time. A free reads its bitmap word on acceptance
// and writes it back with the bit cleared; an allocate reads one 32-bit word per
// cycle through the store's single read port until it finds a free bit or reaches
// the last word. Out-of-range requests skip the bitmap and fail. The next request
// is accepted in the cycle after the output register is loaded. first_index is
// written through i_cfg_we and i_cfg_wdata; the user must write it only while the
// block is idle, unchecked by the block. Reset marks every identifier free at once
// through per-word valid bits, with no clearing pass, and sets first_index to 3.
// A finished result waits in the output register while the receiver stalls; the
// next request may be accepted meanwhile but its result waits for the register.
module bitmap_lowest_free_id_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bmlfa_pkg::ID_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bmlfa_pkg::t_req               i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bmlfa_pkg::t_rsp               o_out_data
);

    bmlfa_pkg::t_mem_req              mem_req;
    logic [bmlfa_pkg::WORD_W-1:0]     rd_data;

    bmlfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data)
    );

    bmlfa_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule

// ===== sim/bitmap_lowest_free_id_allocator_top_tb.sv =====
// Self-checking testbench for the lowest free identifier allocator with a bitmap predictor.
`timescale 1ns / 1ps

module bitmap_lowest_free_id_allocator_top_tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [bmlfa_pkg::ID_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    bmlfa_pkg::t_req in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    bmlfa_pkg::t_rsp out_data;

    logic [bmlfa_pkg::ID_LIMIT-1:0] used_map = '0;
    logic [bmlfa_pkg::ID_W-1:0] first_idx = bmlfa_pkg::FIRST_INDEX_RESET;
    bmlfa_pkg::t_req req_backlog[$];
    bmlfa_pkg::t_rsp owed_replies[$];
    int mismatches = 0;
    int cycle_count = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int replies_seen = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    bitmap_lowest_free_id_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_draw(input bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic bmlfa_pkg::t_rsp grant_or_release(input bmlfa_pkg::t_req req);
        bmlfa_pkg::t_rsp rsp;
        rsp.status      = bmlfa_pkg::ST_FAIL;
        rsp.given_index = '0;
        if (req.opcode == bmlfa_pkg::OP_ALLOC) begin
            for (int id = int'(first_idx); id < bmlfa_pkg::ID_LIMIT; id++) begin
                if (!used_map[id]) begin
                    used_map[id]    = 1'b1;
                    rsp.status      = bmlfa_pkg::ST_OK;
                    rsp.given_index = bmlfa_pkg::ID_W'(id);
                    break;
                end
            end
        end else if (int'(req.free_index) < bmlfa_pkg::ID_COUNT) begin
            used_map[req.free_index] = 1'b0;
            rsp.status               = bmlfa_pkg::ST_OK;
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            send_wait <= 0;
        end else begin
            if (in_valid && in_ready) begin
                owed_replies.push_back(grant_or_release(in_data));
            end
            if (!in_valid || in_ready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    in_valid  <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    in_valid  <= 1'b1;
                    in_data   <= req_backlog.pop_front();
                    send_wait <= idle_draw(send_calm);
                    if ($urandom_range(0, 49) == 0) begin
                        send_calm <= !send_calm;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : reply_check
        bmlfa_pkg::t_rsp want;
        int   wait_n;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (owed_replies.size() == 0) begin
                    $error("unexpected transfer: status %0d given_index %0d",
                           out_data.status, out_data.given_index);
                    mismatches++;
                end else begin
                    want = owed_replies.pop_front();
                    if (out_data.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, out_data.status);
                        mismatches++;
                    end
                    if (out_data.given_index !== want.given_index) begin
                        $error("given_index mismatch: expected %0d, actual %0d",
                               want.given_index, out_data.given_index);
                        mismatches++;
                    end
                end
                replies_seen <= replies_seen + 1;
                if (replies_seen % 700 == 300) begin
                    wait_n = HOLD_CYCLES;
                end else begin
                    wait_n = idle_draw(recv_calm);
                end
                if ($urandom_range(0, 49) == 0) begin
                    recv_calm <= !recv_calm;
                end
                recv_wait <= wait_n;
                out_ready <= (wait_n == 0);
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                out_ready <= (recv_wait == 1);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_req(input logic op, input int idx);
        bmlfa_pkg::t_req req;
        req.opcode     = op;
        req.free_index = bmlfa_pkg::ID_W'(idx);
        req_backlog.push_back(req);
    endtask

    task automatic settle();
        while (req_backlog.size() != 0 || in_valid || owed_replies.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_first_index(input int value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= bmlfa_pkg::ID_W'(value);
        first_idx = bmlfa_pkg::ID_W'(value);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_phase(input int count, input int alloc_pct);
        int top;
        int idx;
        logic op;
        top = (int'(first_idx) + 63 > bmlfa_pkg::ID_COUNT - 1) ? bmlfa_pkg::ID_COUNT - 1
                                                                : int'(first_idx) + 63;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 99) < alloc_pct) ? bmlfa_pkg::OP_ALLOC : bmlfa_pkg::OP_FREE;
            case ($urandom_range(0, 3))
                0, 1: idx = $urandom_range(int'(first_idx), top);
                2: idx = $urandom_range(0, bmlfa_pkg::ID_COUNT - 1);
                default: idx = $urandom_range(0, int'(first_idx));
            endcase
            queue_req(op, idx);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_req(bmlfa_pkg::OP_ALLOC, 0);
        queue_req(bmlfa_pkg::OP_ALLOC, 0);
        queue_req(bmlfa_pkg::OP_ALLOC, bmlfa_pkg::ID_COUNT - 1);
        queue_req(bmlfa_pkg::OP_FREE, 4);
        queue_req(bmlfa_pkg::OP_FREE, 4);
        queue_req(bmlfa_pkg::OP_FREE, 0);
        queue_req(bmlfa_pkg::OP_FREE, bmlfa_pkg::ID_COUNT - 1);
        queue_req(bmlfa_pkg::OP_ALLOC, 682);
        queue_req(bmlfa_pkg::OP_FREE, 3);
        queue_req(bmlfa_pkg::OP_FREE, 5);
        settle();
        set_first_index(bmlfa_pkg::ID_COUNT - 1);
        queue_req(bmlfa_pkg::OP_ALLOC, 341);
        queue_req(bmlfa_pkg::OP_ALLOC, 0);
        queue_req(bmlfa_pkg::OP_FREE, bmlfa_pkg::ID_COUNT - 1);
        queue_req(bmlfa_pkg::OP_ALLOC, 0);
        queue_req(bmlfa_pkg::OP_FREE, bmlfa_pkg::ID_COUNT - 1);
        settle();
        set_first_index(0);
        queue_req(bmlfa_pkg::OP_ALLOC, 0);
        queue_req(bmlfa_pkg::OP_ALLOC, 0);
        queue_req(bmlfa_pkg::OP_FREE, 0);
        queue_req(bmlfa_pkg::OP_FREE, 1);
        queue_req(bmlfa_pkg::OP_FREE, 4);
        settle();

        set_first_index(0);
        random_phase(220, 60);
        settle();
        set_first_index(bmlfa_pkg::ID_COUNT - 1);
        random_phase(220, 50);
        settle();
        set_first_index(990);
        random_phase(220, 70);
        settle();
        set_first_index(512);
        random_phase(220, 65);
        settle();
        set_first_index($urandom_range(1, bmlfa_pkg::ID_COUNT - 2));
        random_phase(220, 60);
        settle();
        set_first_index(1000);
        random_phase(220, 70);
        settle();
        set_first_index(0);
        random_phase(220, 55);
        settle();
        set_first_index(3);
        random_phase(220, 60);
        settle();

        if (mismatches == 0 && owed_replies.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
